// ===== rtl/pfws_pkg.sv =====
// Package for the wheel-speed follower: state encoding, loop constants and widths.
// Depends on nothing; the follower top level refers to it by scoped names.
`default_nettype none

package pfws_pkg;

	// Register indexes (byte address bit 2)
	localparam logic REG_LINEAR_GAIN = 1'b0;
	localparam logic REG_TURN_GAIN   = 1'b1;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int PROX_W = 12;
	localparam int GAIN_W = 6;
	localparam int SPEED_W = 12;
	localparam int INTEG_W = 16;

	localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST = 6'd4;
	localparam logic [GAIN_W-1:0] TURN_GAIN_RST   = 6'd2;

	// Distance is sum/50, taken as (sum * 5243) >> 18; exact for sums up to 8190
	localparam int RECIP_50   = 5243;
	localparam int RECIP_SHIFT = 18;

	localparam int SETPOINT_DIST = 100;
	localparam int SPEED_LIMIT   = 999;
	localparam int SPEED_TRIP    = 1000;
	localparam int INT_CAP_HIGH  = 60;
	localparam int INT_FLOOR_LOW = -10;
	localparam int INT_RATIO     = 60;
	localparam int INT_MAX16     = 32767;
	localparam int INT_MIN16     = -32768;

	// Restoring division 999 / gain: one quotient bit per step
	localparam int DIV_STEPS = 10;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIST  = 7'b0000010,
		ST_ERR   = 7'b0000100,
		ST_INTEG = 7'b0001000,
		ST_LMUL  = 7'b0010000,
		ST_AMUL  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/pi_follow_wheel_speed_controller.sv =====
// Wheel-speed follower top level: PI distance loop, P position loop, APB gain registers.
// Depends on pfws_pkg for constants and the sequencer state type.
//
// Usage:
//   Input channel (in_valid/in_ready) carries four front proximity readings per
//   transaction. Output channel (out_valid/out_ready) carries one pair of wheel
//   speeds per input transaction, in order. Gains are written over the APB port
//   (linear_gain at 0x0, turn_gain at 0x4) while the block is idle.
//   An accepted item passes the states DIST, ERR, INTEG, LMUL, AMUL and FIN in
//   order. One shared multiplier serves three steps (distance reciprocal,
//   linear gain, turn gain) and a restoring divider forms 999/linear_gain one
//   quotient bit per cycle; FIN waits for the ten divider steps to finish.
//   New items are taken only in IDLE: in_ready rises together with out_valid.
//   A finished result waits in the output register; the next item is accepted
//   meanwhile, and its final step holds until the receiver takes the previous one.
//   Reset: gains return to 4 and 2, the integral clears to zero, both channels idle.
`default_nettype none

module pi_follow_wheel_speed_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pfws_pkg::ADDR_W-1:0]        paddr,
	input  logic [pfws_pkg::DATA_W-1:0]        pwdata,
	output logic [pfws_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pfws_pkg::PROX_W-1:0]        prox_right_front,
	input  logic [pfws_pkg::PROX_W-1:0]        prox_right_diag,
	input  logic [pfws_pkg::PROX_W-1:0]        prox_left_diag,
	input  logic [pfws_pkg::PROX_W-1:0]        prox_left_front,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pfws_pkg::SPEED_W-1:0] left_wheel_speed,
	output logic signed [pfws_pkg::SPEED_W-1:0] right_wheel_speed
);

	// Configuration registers
	logic [pfws_pkg::GAIN_W-1:0] lin_gain_q;
	logic [pfws_pkg::GAIN_W-1:0] turn_gain_q;
	logic                        cfg_wr;

	// Sequencer and datapath registers
	pfws_pkg::state_t                  state_q;
	logic [12:0]                       sum_q;
	logic signed [13:0]                pos_q;
	logic signed [7:0]                 err_q;
	logic signed [pfws_pkg::INTEG_W-1:0] integ_q;
	logic signed [22:0]                lin_q;
	logic signed [26:0]                prod_q;

	// Divider registers
	logic [5:0]                        div_rem_q;
	logic [9:0]                        div_quo_q;
	logic [3:0]                        div_cnt_q;

	// Output register
	logic                              out_valid_q;
	logic signed [pfws_pkg::SPEED_W-1:0] left_q;
	logic signed [pfws_pkg::SPEED_W-1:0] right_q;

	logic in_acc;
	logic fin_go;

	// Shared multiplier
	logic signed [17:0] mul_a;
	logic signed [14:0] mul_b;
	logic signed [32:0] mul_p;

	// Distance / error
	logic [7:0]         dist_val;
	logic signed [7:0]  err_d;

	// Integral update
	logic signed [22:0] int_x60;
	logic signed [22:0] int_n;
	logic signed [2:0]  int_adj;
	logic signed [17:0] int_sum;
	logic signed [pfws_pkg::INTEG_W-1:0] int_upd;

	// Divider step
	logic [6:0] div_trial;
	logic       div_ge;
	logic       div_done;

	// Final step
	logic signed [11:0] quo_s;
	logic signed [11:0] v_hi;
	logic signed [11:0] v_lo;
	logic signed [11:0] lin_sat;
	logic signed [11:0] ang_sat;
	logic signed [pfws_pkg::INTEG_W-1:0] int_fin;

	// ------------------------------------------------------------------
	// APB: zero wait states, writes land on the access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q  <= pfws_pkg::LINEAR_GAIN_RST;
			turn_gain_q <= pfws_pkg::TURN_GAIN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == pfws_pkg::REG_LINEAR_GAIN) begin
				lin_gain_q <= pwdata[pfws_pkg::GAIN_W-1:0];
			end else begin
				turn_gain_q <= pwdata[pfws_pkg::GAIN_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == pfws_pkg::REG_LINEAR_GAIN) begin
			prdata = {{(pfws_pkg::DATA_W-pfws_pkg::GAIN_W){1'b0}}, lin_gain_q};
		end else begin
			prdata = {{(pfws_pkg::DATA_W-pfws_pkg::GAIN_W){1'b0}}, turn_gain_q};
		end
	end

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign in_ready  = (state_q == pfws_pkg::ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign left_wheel_speed  = left_q;
	assign right_wheel_speed = right_q;

	// Final step fires once the quotient is ready and the output register is free
	assign div_done = (div_cnt_q == 4'd0);
	assign fin_go   = (state_q == pfws_pkg::ST_FIN) & div_done & (~out_valid_q | out_ready);

	// ------------------------------------------------------------------
	// Shared multiplier: operand select per step, product registered
	// ------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pfws_pkg::ST_DIST: begin
				mul_a = signed'({5'b0, sum_q});
				mul_b = 15'(pfws_pkg::RECIP_50);
			end
			pfws_pkg::ST_LMUL: begin
				mul_a = 18'(err_q) + 18'(integ_q);
				mul_b = signed'({9'b0, lin_gain_q});
			end
			pfws_pkg::ST_AMUL: begin
				// angular speed is minus position times gain
				mul_a = 18'(pos_q);
				mul_b = -signed'({9'b0, turn_gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Distance error from the reciprocal product
	// ------------------------------------------------------------------
	assign dist_val = prod_q[pfws_pkg::RECIP_SHIFT+7:pfws_pkg::RECIP_SHIFT];
	assign err_d    = signed'(8'(pfws_pkg::SETPOINT_DIST) - dist_val);

	// ------------------------------------------------------------------
	// Integral: trunc((60*I + err)/60) = I + floor or ceil of err/60,
	// chosen by the sign of 60*I + err; err stays within -63..100.
	// ------------------------------------------------------------------
	assign int_x60 = (23'(integ_q) <<< 6) - (23'(integ_q) <<< 2);
	assign int_n   = int_x60 + 23'(err_q);

	always_comb begin
		if (!int_n[22]) begin
			priority if (err_q >= 8'(pfws_pkg::INT_RATIO))  int_adj = 3'sd1;
			else if (err_q >= 8'sd0)                         int_adj = 3'sd0;
			else if (err_q >= -8'(pfws_pkg::INT_RATIO))      int_adj = -3'sd1;
			else                                             int_adj = -3'sd2;
		end else begin
			priority if (err_q > 8'(pfws_pkg::INT_RATIO))   int_adj = 3'sd2;
			else if (err_q > 8'sd0)                          int_adj = 3'sd1;
			else if (err_q > -8'(pfws_pkg::INT_RATIO))       int_adj = 3'sd0;
			else                                             int_adj = -3'sd1;
		end
	end

	assign int_sum = 18'(integ_q) + 18'(int_adj);

	always_comb begin
		priority if (int_sum > 18'(pfws_pkg::INT_MAX16))      int_upd = 16'(pfws_pkg::INT_MAX16);
		else if (int_sum < 18'(pfws_pkg::INT_MIN16))          int_upd = 16'(pfws_pkg::INT_MIN16);
		else                                                  int_upd = int_sum[15:0];
	end

	// ------------------------------------------------------------------
	// Restoring divider: 999 / linear_gain, one bit per cycle
	// ------------------------------------------------------------------
	assign div_trial = {div_rem_q, div_quo_q[9]};
	assign div_ge    = (div_trial >= {1'b0, lin_gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (in_acc) begin
			div_cnt_q <= 4'(pfws_pkg::DIV_STEPS);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			div_rem_q <= '0;
			div_quo_q <= 10'(pfws_pkg::SPEED_LIMIT);
		end else if (!div_done) begin
			div_rem_q <= div_ge ? 6'(div_trial - {1'b0, lin_gain_q}) : div_trial[5:0];
			div_quo_q <= {div_quo_q[8:0], div_ge};
		end
	end

	// ------------------------------------------------------------------
	// Final step: saturate both speeds, back-calculate the integral
	// ------------------------------------------------------------------
	assign quo_s = signed'({2'b0, div_quo_q});
	assign v_hi  = quo_s - 12'(err_q);
	assign v_lo  = 12'(err_q) - quo_s;

	always_comb begin
		priority if (lin_q >= 23'(pfws_pkg::SPEED_TRIP)) begin
			lin_sat = 12'(pfws_pkg::SPEED_LIMIT);
			int_fin = (v_hi > 12'(pfws_pkg::INT_CAP_HIGH)) ?
				16'(pfws_pkg::INT_CAP_HIGH) : 16'(v_hi);
		end else if (lin_q <= -23'(pfws_pkg::SPEED_TRIP)) begin
			lin_sat = -12'(pfws_pkg::SPEED_LIMIT);
			int_fin = (v_lo < 12'(pfws_pkg::INT_FLOOR_LOW)) ?
				16'(pfws_pkg::INT_FLOOR_LOW) : 16'(v_lo);
		end else begin
			lin_sat = lin_q[11:0];
			int_fin = integ_q;
		end
	end

	always_comb begin
		priority if (prod_q >= 27'(pfws_pkg::SPEED_TRIP))     ang_sat = 12'(pfws_pkg::SPEED_LIMIT);
		else if (prod_q <= -27'(pfws_pkg::SPEED_TRIP))        ang_sat = -12'(pfws_pkg::SPEED_LIMIT);
		else                                                  ang_sat = prod_q[11:0];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfws_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				pfws_pkg::ST_IDLE:  if (in_acc) state_q <= pfws_pkg::ST_DIST;
				pfws_pkg::ST_DIST:  state_q <= pfws_pkg::ST_ERR;
				pfws_pkg::ST_ERR:   state_q <= pfws_pkg::ST_INTEG;
				pfws_pkg::ST_INTEG: state_q <= pfws_pkg::ST_LMUL;
				pfws_pkg::ST_LMUL:  state_q <= pfws_pkg::ST_AMUL;
				pfws_pkg::ST_AMUL:  state_q <= pfws_pkg::ST_FIN;
				pfws_pkg::ST_FIN:   if (fin_go) state_q <= pfws_pkg::ST_IDLE;
				default:            state_q <= pfws_pkg::ST_IDLE;
			endcase
		end
	end

	// Integral state: reset to zero, updated twice per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (state_q == pfws_pkg::ST_INTEG) begin
			integ_q <= int_upd;
		end else if (fin_go) begin
			integ_q <= int_fin;
		end
	end

	// Datapath payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q <= 13'(prox_right_front) + 13'(prox_left_front);
			pos_q <= signed'(14'(prox_right_front) + 14'(prox_right_diag)
				- 14'(prox_left_front) - 14'(prox_left_diag));
		end
		if (state_q == pfws_pkg::ST_ERR) begin
			err_q <= err_d;
		end
		if (state_q == pfws_pkg::ST_AMUL) begin
			lin_q <= prod_q[22:0];
		end
		if ((state_q == pfws_pkg::ST_DIST) || (state_q == pfws_pkg::ST_LMUL) ||
			(state_q == pfws_pkg::ST_AMUL)) begin
			prod_q <= mul_p[26:0];
		end
	end

	// Output register: hold until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			left_q  <= lin_sat - ang_sat;
			right_q <= lin_sat + ang_sat;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == pfws_pkg::ST_DIST)
		else $error("accepted item did not start the sequence");

	a_fin_needs_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |-> div_cnt_q == 4'd0)
		else $error("final step ran before the divider finished");

	a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfws_pkg::ST_FIN && out_valid_q && !out_ready |=>
		state_q == pfws_pkg::ST_FIN && $stable(left_q) && $stable(right_q))
		else $error("pending result overwritten while stalled");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> left_q >= -12'sd1998 && left_q <= 12'sd1998 &&
		right_q >= -12'sd1998 && right_q <= 12'sd1998)
		else $error("wheel speed out of range");
`endif

endmodule

`default_nettype wire
